>>> src/ovn_pkg.sv
// Shared types, constants and functions for the octave value noise block
`timescale 1ns / 1ps
`default_nettype none
package ovn_pkg;

    localparam int CNT_W   = 5;   // octave count, up to fifteen
    localparam int OCT_W   = 4;   // octave index
    localparam int MAG_W   = 48;  // scaled magnitude, Q16
    localparam int AMP_W   = 25;  // amplitude, Q15, capped at 2^24
    localparam int ACC_W   = 48;  // exact Q29 sum
    localparam logic [AMP_W-1:0] AMP_CAP   = 25'h100_0000;
    localparam logic [AMP_W-1:0] AMP_START = 25'd32768;
    localparam longint unsigned  PI_Q30    = 64'd3373259426;
    localparam int unsigned COS_DIV [1:12] = '{2, 12, 30, 56, 90, 132,
                                               182, 240, 306, 380, 462, 552};

    typedef enum logic [1:0] {
        REG_OCTAVE_COUNT = 2'd0,
        REG_INV_ZOOM     = 2'd1,
        REG_PERSISTENCE  = 2'd2,
        REG_SEED         = 2'd3
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SCALE, ST_CELL, ST_HASH, ST_DRAIN,
        ST_SMOOTH, ST_BLEND_X, ST_BLEND_Y, ST_ACCUM, ST_FINISH
    } back_state_t;

    // classified point handed from front to back
    typedef struct packed {
        logic [15:0]      ax;
        logic [15:0]      ay;
        logic             neg_x;
        logic             neg_y;
        logic [CNT_W-1:0] count;
    } item_t;

    typedef struct packed {
        logic        valid;
        logic [31:0] x;
        logic [31:0] y;
        logic [3:0]  tag;
    } hash_req_t;

    typedef struct packed {
        logic               valid;
        logic [3:0]         tag;
        logic signed [15:0] value;
    } hash_rsp_t;

    // (1 - cos(pi*k/2^bits)) / 2 in Q14, series in Q30; elaboration only
    function automatic logic [14:0] half_weight(int unsigned k, int unsigned bits);
        longint unsigned th;
        longint unsigned th2;
        longint unsigned term;
        longint          omc;
        longint unsigned r;
        th   = (PI_Q30 * longint'(k)) >> bits;
        th2  = (th * th) >> 30;
        term = 64'd1 << 30;
        omc  = 0;
        for (int j = 1; j <= 12; j++) begin
            term = ((term * th2) >> 30) / COS_DIV[j];
            if (j % 2 == 1)
                omc = omc + longint'(term);
            else
                omc = omc - longint'(term);
        end
        if (omc < 0)
            omc = 0;
        r = (longint'(omc) + (64'd1 << 16)) >> 17;
        return r[14:0];
    endfunction

    function automatic logic [14:0] blend_weight(int unsigned idx, int unsigned bits);
        int unsigned full;
        full = 1 << bits;
        if (2 * idx > full)
            return 15'(16384 - int'(half_weight(full - idx, bits)));
        return half_weight(idx, bits);
    endfunction

    // a + floor((b - a) * f / 2^14)
    function automatic logic signed [15:0] blend(logic signed [15:0] a,
                                                 logic signed [15:0] b,
                                                 logic [14:0] f);
        logic signed [16:0] d;
        logic signed [32:0] p;
        logic signed [18:0] s;
        d = {b[15], b} - {a[15], a};
        p = 33'(d) * 33'($signed({1'b0, f}));
        s = {{3{a[15]}}, a} + p[32:14];
        return s[15:0];
    endfunction

    // 3x3 smoothing: corners/16, sides/8, centre/4, floored
    function automatic logic signed [15:0] smooth(
        logic signed [15:0] ul, logic signed [15:0] um, logic signed [15:0] ur,
        logic signed [15:0] ml, logic signed [15:0] mm, logic signed [15:0] mr,
        logic signed [15:0] ll, logic signed [15:0] lm, logic signed [15:0] lr);
        logic signed [20:0] c;
        logic signed [20:0] s;
        logic signed [20:0] t;
        c = 21'(ul) + 21'(ur) + 21'(ll) + 21'(lr);
        s = 21'(um) + 21'(ml) + 21'(mr) + 21'(lm);
        t = c + (s <<< 1) + (21'(mm) <<< 2);
        return t[19:4];
    endfunction

endpackage
`default_nettype wire

>>> src/ovn_if.sv
// Point and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface ovn_point_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] point_x;
    logic signed [15:0] point_y;
    modport source (output valid, output point_x, output point_y, input ready);
    modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

interface ovn_result_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] noise_total;
    logic               saturated;
    modport source (output valid, output noise_total, output saturated, input ready);
    modport sink   (input valid, input noise_total, input saturated, output ready);
endinterface
`default_nettype wire

>>> src/ovn_front.sv
// Front end: takes points, splits sign and magnitude, clamps the count, queues
`timescale 1ns / 1ps
`default_nettype none
module ovn_front #(
    parameter int MAX_OCTAVES = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    ovn_point_if.sink            point,
    input  wire logic [3:0]      octave_count,
    output logic                 item_valid,
    output ovn_pkg::item_t       item,
    input  wire logic            item_take
);
    ovn_pkg::item_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    ovn_pkg::item_t in_item;
    logic           push;
    logic           pop;

    // classify the incoming point
    always_comb
    begin
        in_item.neg_x = point.point_x[15];
        in_item.neg_y = point.point_y[15];
        in_item.ax    = point.point_x[15] ? 16'(-point.point_x) : point.point_x;
        in_item.ay    = point.point_y[15] ? 16'(-point.point_y) : point.point_y;
        if (32'(octave_count) > MAX_OCTAVES)
            in_item.count = ovn_pkg::CNT_W'(MAX_OCTAVES);
        else
            in_item.count = ovn_pkg::CNT_W'(octave_count);
    end

    assign point.ready = (fill_reg != 2'd2);
    assign push        = point.valid && point.ready;
    assign pop         = item_take && item_valid;
    assign item_valid  = (fill_reg != 2'd0);
    assign item        = q_reg[rd_ptr_reg];

    // queue pointers
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = 2'(fill_reg + {1'b0, push} - {1'b0, pop});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wr_ptr_reg] <= in_item;
    end
endmodule
`default_nettype wire

>>> src/ovn_hash.sv
// Four-stage lattice hash pipeline, one lattice point per cycle
`timescale 1ns / 1ps
`default_nettype none
module ovn_hash (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic [31:0]     seed,
    input  ovn_pkg::hash_req_t   req,
    output ovn_pkg::hash_rsp_t   rsp
);
    logic [31:0] n0;
    logic [31:0] na_reg, nb_reg, nc_reg;
    logic [31:0] sq_reg;
    logic [31:0] m_reg;
    logic [31:0] t;
    logic [3:0]  tag_a_reg, tag_b_reg, tag_c_reg;
    logic        v_a_reg, v_b_reg, v_c_reg;
    logic               rsp_valid_reg;
    logic [3:0]         rsp_tag_reg;
    logic signed [15:0] rsp_value_reg;

    // mix coordinates and seed
    assign n0 = 32'(req.x + req.y * 32'd57 + seed);
    assign t  = 32'(nc_reg * m_reg + 32'd1376312589) & 32'h7fff_ffff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_a_reg       <= 1'b0;
            v_b_reg       <= 1'b0;
            v_c_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            v_a_reg       <= req.valid;
            v_b_reg       <= v_a_reg;
            v_c_reg       <= v_b_reg;
            rsp_valid_reg <= v_c_reg;
        end
    end

    // one multiply per stage
    always_ff @(posedge clk)
    begin
        na_reg        <= (n0 << 13) ^ n0;
        tag_a_reg     <= req.tag;
        sq_reg        <= 32'(na_reg * na_reg);
        nb_reg        <= na_reg;
        tag_b_reg     <= tag_a_reg;
        m_reg         <= 32'(sq_reg * 32'd15731 + 32'd789221);
        nc_reg        <= nb_reg;
        tag_c_reg     <= tag_b_reg;
        rsp_tag_reg   <= tag_c_reg;
        rsp_value_reg <= 16'sd16384 - $signed({1'b0, t[30:16]});
    end

    assign rsp = {rsp_valid_reg, rsp_tag_reg, rsp_value_reg};
endmodule
`default_nettype wire

>>> src/ovn_back.sv
// Back end: octave sequencer, 4x4 lattice grid, smoothing, blend and sum
`timescale 1ns / 1ps
`default_nettype none
module ovn_back #(
    parameter int COS_TABLE_BITS = 8
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            item_valid,
    input  ovn_pkg::item_t       item,
    output logic                 item_take,
    input  wire logic [23:0]     inv_zoom,
    input  wire logic [15:0]     persistence,
    input  wire logic [31:0]     seed,
    ovn_result_if.source         result
);
    localparam int WT_DEPTH = 2 ** COS_TABLE_BITS;

    // blend weight ROM
    logic [14:0] w_rom [WT_DEPTH];
    for (genvar k = 0; k < WT_DEPTH; k++)
    begin : g_rom
        localparam logic [14:0] W = ovn_pkg::blend_weight(k, COS_TABLE_BITS);
        assign w_rom[k] = W;
    end

    ovn_pkg::back_state_t state_reg, state_next;
    ovn_pkg::item_t       it_reg;
    logic [39:0]          magx_reg, magy_reg;
    logic [ovn_pkg::OCT_W-1:0] oct_reg;
    logic [31:0]          ux_reg, uy_reg;
    logic [14:0]          wx_reg, wy_reg;
    logic [3:0]           hc_reg;
    logic signed [15:0]   g_reg [16];
    logic signed [15:0]   v_reg [4];
    logic signed [15:0]   bx0_reg, bx1_reg, n_reg;
    logic [ovn_pkg::AMP_W-1:0] amp_reg;
    logic signed [ovn_pkg::ACC_W-1:0] acc_reg;
    logic                 res_valid_reg;
    logic signed [15:0]   res_noise_reg;
    logic                 res_sat_reg;

    logic [ovn_pkg::MAG_W-1:0] mx, my;
    logic [31:0]          ux_next, uy_next;
    ovn_pkg::hash_req_t   hreq;
    ovn_pkg::hash_rsp_t   hrsp;
    logic                 last_octave;
    logic                 out_free;
    logic                 ld_scale, ld_cell, ld_smooth, ld_bx, ld_by, ld_acc, ld_res;
    logic signed [41:0]   nprod;
    logic [40:0]          aprod;
    logic [25:0]          ap_sh;
    logic [ovn_pkg::AMP_W-1:0] amp_next;
    logic signed [30:0]   q;

    ovn_hash u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .seed  (seed),
        .req   (hreq),
        .rsp   (hrsp)
    );

    assign last_octave = (ovn_pkg::CNT_W'(oct_reg) + 1'b1) == it_reg.count;
    assign out_free    = !res_valid_reg || result.ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ovn_pkg::ST_IDLE:    if (item_valid) state_next = ovn_pkg::ST_SCALE;
            ovn_pkg::ST_SCALE:   state_next = (it_reg.count == '0) ? ovn_pkg::ST_FINISH
                                                                  : ovn_pkg::ST_CELL;
            ovn_pkg::ST_CELL:    state_next = ovn_pkg::ST_HASH;
            ovn_pkg::ST_HASH:    if (hc_reg == 4'd15) state_next = ovn_pkg::ST_DRAIN;
            ovn_pkg::ST_DRAIN:   if (hrsp.valid && hrsp.tag == 4'd15)
                                     state_next = ovn_pkg::ST_SMOOTH;
            ovn_pkg::ST_SMOOTH:  state_next = ovn_pkg::ST_BLEND_X;
            ovn_pkg::ST_BLEND_X: state_next = ovn_pkg::ST_BLEND_Y;
            ovn_pkg::ST_BLEND_Y: state_next = ovn_pkg::ST_ACCUM;
            ovn_pkg::ST_ACCUM:   state_next = last_octave ? ovn_pkg::ST_FINISH
                                                          : ovn_pkg::ST_CELL;
            ovn_pkg::ST_FINISH:  if (out_free) state_next = ovn_pkg::ST_IDLE;
            default:             state_next = ovn_pkg::ST_IDLE;
        endcase
    end

    // strobes
    always_comb
    begin
        item_take = (state_reg == ovn_pkg::ST_IDLE) && item_valid;
        ld_scale  = (state_reg == ovn_pkg::ST_SCALE);
        ld_cell   = (state_reg == ovn_pkg::ST_CELL);
        ld_smooth = (state_reg == ovn_pkg::ST_SMOOTH);
        ld_bx     = (state_reg == ovn_pkg::ST_BLEND_X);
        ld_by     = (state_reg == ovn_pkg::ST_BLEND_Y);
        ld_acc    = (state_reg == ovn_pkg::ST_ACCUM);
        ld_res    = (state_reg == ovn_pkg::ST_FINISH) && out_free;
    end

    // cell and fraction of this octave
    always_comb
    begin
        mx      = {8'd0, magx_reg} << oct_reg;
        my      = {8'd0, magy_reg} << oct_reg;
        ux_next = it_reg.neg_x ? 32'(32'd0 - mx[47:16]) : mx[47:16];
        uy_next = it_reg.neg_y ? 32'(32'd0 - my[47:16]) : my[47:16];
    end

    // lattice point of the 4x4 grid around the cell
    always_comb
    begin
        hreq.valid = (state_reg == ovn_pkg::ST_HASH);
        hreq.tag   = hc_reg;
        hreq.x     = 32'(ux_reg + {30'd0, hc_reg[1:0]} - 32'd1);
        hreq.y     = 32'(uy_reg + {30'd0, hc_reg[3:2]} - 32'd1);
    end

    // octave weighting
    always_comb
    begin
        nprod    = 42'(n_reg) * 42'($signed({1'b0, amp_reg}));
        aprod    = 41'(amp_reg) * 41'(persistence);
        ap_sh    = aprod[40:15];
        amp_next = (ap_sh > 26'(ovn_pkg::AMP_CAP)) ? ovn_pkg::AMP_CAP : ap_sh[24:0];
        q        = acc_reg[47:17];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ovn_pkg::ST_IDLE;
            hc_reg        <= 4'd0;
            oct_reg       <= '0;
            amp_reg       <= ovn_pkg::AMP_START;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (hreq.valid)
                hc_reg <= 4'(hc_reg + 4'd1);
            if (ld_scale)
            begin
                oct_reg <= '0;
                amp_reg <= ovn_pkg::AMP_START;
            end
            else if (ld_acc)
            begin
                oct_reg <= ovn_pkg::OCT_W'(oct_reg + 1'b1);
                amp_reg <= amp_next;
            end
            if (ld_res)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (item_take)
            it_reg <= item;
        if (ld_scale)
        begin
            magx_reg <= 40'(it_reg.ax) * 40'(inv_zoom);
            magy_reg <= 40'(it_reg.ay) * 40'(inv_zoom);
            acc_reg  <= '0;
        end
        if (ld_cell)
        begin
            ux_reg <= ux_next;
            uy_reg <= uy_next;
            wx_reg <= w_rom[mx[15 -: COS_TABLE_BITS]];
            wy_reg <= w_rom[my[15 -: COS_TABLE_BITS]];
        end
        if (hrsp.valid)
            g_reg[hrsp.tag] <= hrsp.value;
        if (ld_smooth)
        begin
            v_reg[0] <= ovn_pkg::smooth(g_reg[0], g_reg[1], g_reg[2], g_reg[4], g_reg[5],
                                        g_reg[6], g_reg[8], g_reg[9], g_reg[10]);
            v_reg[1] <= ovn_pkg::smooth(g_reg[1], g_reg[2], g_reg[3], g_reg[5], g_reg[6],
                                        g_reg[7], g_reg[9], g_reg[10], g_reg[11]);
            v_reg[2] <= ovn_pkg::smooth(g_reg[4], g_reg[5], g_reg[6], g_reg[8], g_reg[9],
                                        g_reg[10], g_reg[12], g_reg[13], g_reg[14]);
            v_reg[3] <= ovn_pkg::smooth(g_reg[5], g_reg[6], g_reg[7], g_reg[9], g_reg[10],
                                        g_reg[11], g_reg[13], g_reg[14], g_reg[15]);
        end
        if (ld_bx)
        begin
            bx0_reg <= ovn_pkg::blend(v_reg[0], v_reg[1], wx_reg);
            bx1_reg <= ovn_pkg::blend(v_reg[2], v_reg[3], wx_reg);
        end
        if (ld_by)
            n_reg <= ovn_pkg::blend(bx0_reg, bx1_reg, wy_reg);
        if (ld_acc)
            acc_reg <= acc_reg + ovn_pkg::ACC_W'(nprod);
        if (ld_res)
        begin
            if (q > 31'sd32767)
            begin
                res_noise_reg <= 16'sh7fff;
                res_sat_reg   <= 1'b1;
            end
            else if (q < -31'sd32768)
            begin
                res_noise_reg <= -16'sh8000;
                res_sat_reg   <= 1'b1;
            end
            else
            begin
                res_noise_reg <= q[15:0];
                res_sat_reg   <= 1'b0;
            end
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.noise_total = res_noise_reg;
    assign result.saturated   = res_sat_reg;

    // hash results only arrive while the grid is being filled
    a_hash_window: assert property (@(posedge clk) disable iff (!rst_n)
        hrsp.valid |-> (state_reg == ovn_pkg::ST_HASH || state_reg == ovn_pkg::ST_DRAIN))
        else $error("hash result outside grid fill");

    a_amp_cap: assert property (@(posedge clk) disable iff (!rst_n)
        amp_reg <= ovn_pkg::AMP_CAP)
        else $error("amplitude above cap");

    // a finished point waits while the output register is still occupied
    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ovn_pkg::ST_FINISH && res_valid_reg && !result.ready)
        |=> state_reg == ovn_pkg::ST_FINISH)
        else $error("result overwritten");
endmodule
`default_nettype wire

>>> src/octave_value_noise.sv
// Each octave sends the 16 lattice points of its 4x4 grid through the
// shared hash pipeline and waits for its 4-stage drain.
// The back end finishes every octave of one point before it takes the next.
// A two-entry queue takes new points, until it is full, while the back end works.
// Reset: octave_count 4, inv_zoom 1.0, persistence 0.5, seed 0; queue
// and output register empty.
`timescale 1ns / 1ps
`default_nettype none
module octave_value_noise #(
    parameter int MAX_OCTAVES    = 8,
    parameter int COS_TABLE_BITS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    ovn_point_if.sink        point,
    ovn_result_if.source     result
);
    logic [3:0]     octave_count_reg;
    logic [23:0]    inv_zoom_reg;
    logic [15:0]    persistence_reg;
    logic [31:0]    seed_reg;
    logic           item_valid;
    logic           item_take;
    ovn_pkg::item_t item;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= 4'd4;
            inv_zoom_reg     <= 24'd65536;
            persistence_reg  <= 16'd16384;
            seed_reg         <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (ovn_pkg::cfg_reg_t'(cfg_index))
                ovn_pkg::REG_OCTAVE_COUNT: octave_count_reg <= cfg_data[3:0];
                ovn_pkg::REG_INV_ZOOM:     inv_zoom_reg     <= cfg_data[23:0];
                ovn_pkg::REG_PERSISTENCE:  persistence_reg  <= cfg_data[15:0];
                ovn_pkg::REG_SEED:         seed_reg         <= cfg_data;
                default:                   seed_reg         <= seed_reg;
            endcase
        end
    end

    ovn_front #(
        .MAX_OCTAVES (MAX_OCTAVES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .point        (point),
        .octave_count (octave_count_reg),
        .item_valid   (item_valid),
        .item         (item),
        .item_take    (item_take)
    );

    ovn_back #(
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .inv_zoom    (inv_zoom_reg),
        .persistence (persistence_reg),
        .seed        (seed_reg),
        .result      (result)
    );
endmodule
`default_nettype wire
